// File: src/rcpdh_pkg.sv
// ---------------------------------------------------------------------------
// RC packet decoder package
// Shared constants, register indexes, result codes and word types of the
// radio-control frame decoder with channel hopping.
// ---------------------------------------------------------------------------
package rcpdh_pkg;

   // Frame and servo geometry
   localparam int PACKET_BYTES       = 17;
   localparam int SERVO_CHANNELS_DEF = 8;
   localparam int SERVO_OUTS         = 8;
   localparam int SERVO_CHANNELS_MAX = 15;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_HOP_CHAN_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HOP_CHAN_SECOND = 2'd1;
   localparam logic [1:0] CSR_HOP_CHAN_THIRD  = 2'd2;
   localparam logic [1:0] CSR_LINK_TIMEOUT    = 2'd3;

   // Configuration reset values
   localparam logic [7:0]  HOP_CHAN_FIRST_RESET  = 8'd13;
   localparam logic [7:0]  HOP_CHAN_SECOND_RESET = 8'd54;
   localparam logic [7:0]  HOP_CHAN_THIRD_RESET  = 8'd23;
   localparam logic [19:0] LINK_TIMEOUT_RESET    = 20'd25000;

   // Result kinds
   localparam logic [1:0] EVENT_TIMEOUT_HOP = 2'd0;
   localparam logic [1:0] EVENT_FRAME_PLAIN = 2'd1;
   localparam logic [1:0] EVENT_FRAME_SERVO = 2'd2;

   // Hop slots
   localparam logic [1:0] HOP_SLOT_FIRST  = 2'd0;
   localparam logic [1:0] HOP_SLOT_SECOND = 2'd1;
   localparam logic [1:0] HOP_SLOT_THIRD  = 2'd2;
   localparam logic [1:0] HOP_SLOT_RESET  = HOP_SLOT_SECOND;

   // Frame decoding constants
   localparam logic [7:0]  SERVO_TAG       = 8'h53;
   localparam logic [15:0] SERVO_WORD_LOW  = 16'd1500;
   localparam logic [15:0] SERVO_WORD_HIGH = 16'd4500;
   localparam logic [11:0] SERVO_RESET     = 12'd3000;
   localparam logic [9:0]  FAILSAFE_STEP   = 10'd20;
   localparam logic [7:0]  RSSI_FLOOR      = 8'd45;
   localparam logic [7:0]  RSSI_CEILING    = 8'd120;
   localparam logic [7:0]  RSSI_BASE       = 8'd40;
   localparam logic [10:0] RSSI_LEVEL_MIN  = 11'd125;
   localparam logic [10:0] RSSI_LEVEL_MAX  = 11'd2000;

   typedef struct packed {
      logic        mode;
      logic [31:0] now_us;
      logic [7:0]  data_byte;
      logic [7:0]  rssi_raw;
      logic [9:0]  failsafe_in;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                  event_kind;
      logic [7:0]                  hop_channel;
      logic [SERVO_OUTS-1:0][11:0] servo_value;
      logic [10:0]                 rssi_level;
      logic [9:0]                  failsafe_out;
   } rsp_word_type;

   // Push control from the decoder into the result queue
   typedef struct packed {
      logic lead_valid;
      logic trail_valid;
   } push_ctrl_type;

endpackage

// File: src/rcpdh_if.sv
// ---------------------------------------------------------------------------
// RC packet decoder channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ---------------------------------------------------------------------------
interface rcpdh_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] now_us;
   logic [7:0]  data_byte;
   logic [7:0]  rssi_raw;
   logic [9:0]  failsafe_in;

   modport source (output valid, mode, now_us, data_byte, rssi_raw, failsafe_in,
                   input ready);
   modport sink   (input valid, mode, now_us, data_byte, rssi_raw, failsafe_in,
                   output ready);
endinterface

interface rcpdh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  hop_channel;
   logic [11:0] roll_value;
   logic [11:0] pitch_value;
   logic [11:0] throttle_value;
   logic [11:0] yaw_value;
   logic [11:0] aux_one_value;
   logic [11:0] aux_two_value;
   logic [11:0] aux_three_value;
   logic [11:0] aux_four_value;
   logic [10:0] rssi_level;
   logic [9:0]  failsafe_out;

   modport source (output valid, event_kind, hop_channel, roll_value, pitch_value,
                   throttle_value, yaw_value, aux_one_value, aux_two_value,
                   aux_three_value, aux_four_value, rssi_level, failsafe_out,
                   input ready);
   modport sink   (input valid, event_kind, hop_channel, roll_value, pitch_value,
                   throttle_value, yaw_value, aux_one_value, aux_two_value,
                   aux_three_value, aux_four_value, rssi_level, failsafe_out,
                   output ready);
endinterface

interface rcpdh_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [19:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/rcpdh_rsp_queue.sv
// ---------------------------------------------------------------------------
// RC packet decoder result queue
// Small queue that takes up to two result words per cycle and hands them
// out one per cycle on the result channel while the consumer is ready.
// ---------------------------------------------------------------------------
module rcpdh_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rcpdh_pkg::push_ctrl_type push_ctrl,
   input  rcpdh_pkg::rsp_word_type lead_word,
   input  rcpdh_pkg::rsp_word_type trail_word,
   output logic                    room,
   rcpdh_rsp_if.source             rsp_ch
);
   import rcpdh_pkg::*;

   rsp_word_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     head_ff, head_in;
   logic [QUEUE_PTR_W-1:0]     tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       pop;
   logic [QUEUE_PTR_W-1:0]     tail_next;
   rsp_word_type               head_word;

   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign tail_next = tail_ff + QUEUE_PTR_W'(1);
   // Room for the worst case of two words from one input word
   assign room      = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

   always_comb begin
      head_in  = pop ? head_ff + QUEUE_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + QUEUE_PTR_W'(push_ctrl.lead_valid)
                         + QUEUE_PTR_W'(push_ctrl.trail_valid);
      count_in = count_ff + QUEUE_CNT_W'(push_ctrl.lead_valid)
                          + QUEUE_CNT_W'(push_ctrl.trail_valid)
                          - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ctrl.lead_valid) begin
         entry_ff[tail_ff] <= lead_word;
      end
      if (push_ctrl.trail_valid) begin
         entry_ff[tail_next] <= trail_word;
      end
   end

   assign head_word = entry_ff[head_ff];

   assign rsp_ch.valid           = count_ff != '0;
   assign rsp_ch.event_kind      = head_word.event_kind;
   assign rsp_ch.hop_channel     = head_word.hop_channel;
   assign rsp_ch.roll_value      = head_word.servo_value[0];
   assign rsp_ch.pitch_value     = head_word.servo_value[1];
   assign rsp_ch.throttle_value  = head_word.servo_value[2];
   assign rsp_ch.yaw_value       = head_word.servo_value[3];
   assign rsp_ch.aux_one_value   = head_word.servo_value[4];
   assign rsp_ch.aux_two_value   = head_word.servo_value[5];
   assign rsp_ch.aux_three_value = head_word.servo_value[6];
   assign rsp_ch.aux_four_value  = head_word.servo_value[7];
   assign rsp_ch.rssi_level      = head_word.rssi_level;
   assign rsp_ch.failsafe_out    = head_word.failsafe_out;

endmodule

// File: src/rc_packet_decode_hop_unit.sv
// ---------------------------------------------------------------------------
// RC packet decoder with frequency hopping
// Collects radio frame bytes, updates servo values from 'S' frames, maps
// signal strength and hops round-robin over three configured channels.
// ---------------------------------------------------------------------------
// Each input word is captured in an input register when accepted and is
// processed from there once the result queue has room, so one word is taken
// every clock cycle when the result side keeps up. A word gives zero, one or
// two result words: a timeout hop when the time since the last hop exceeds
// the link timeout, and a frame result on the last byte of a frame; when both
// happen the timeout hop comes first. A result is written into the queue from
// the input register and offered from there. Results wait in a four-word queue,
// and the input side stops taking words only while that queue holds more than
// two words and the input register is full, so a slow result consumer
// throttles the input rather than losing data. Register writes are taken in
// any cycle and should only be made while the block is idle.
// ---------------------------------------------------------------------------
module rc_packet_decode_hop_unit #(
   parameter int SERVO_CHANNELS = rcpdh_pkg::SERVO_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcpdh_req_if.sink   req_ch,
   rcpdh_rsp_if.source rsp_ch,
   rcpdh_csr_if.sink   csr_ch
);
   import rcpdh_pkg::*;

   // Configuration registers
   logic [7:0]  hop_chan_ff [3];
   logic [19:0] link_timeout_ff;

   // Input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // Decoder state
   logic [7:0]  frame_tag_ff, frame_tag_in;
   logic [7:0]  high_byte_ff, high_byte_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [11:0] servo_ff [SERVO_CHANNELS];
   logic [11:0] servo_in [SERVO_CHANNELS];
   logic [1:0]  hop_index_ff, hop_index_in;
   logic [31:0] last_hop_ff, last_hop_in;

   // Datapath signals
   logic          room;
   logic          advance;
   logic          req_take;
   logic [31:0]   elapsed;
   logic          timeout_hit;
   logic [1:0]    slot_after_timeout;
   logic [1:0]    slot_after_frame;
   logic [4:0]    count_plus;
   logic          frame_end;
   logic [15:0]   servo_word;
   logic [3:0]    servo_slot;
   logic          servo_write;
   logic          servo_frame;
   logic [7:0]    rssi_clamped;
   logic [10:0]   rssi_offset;
   logic [10:0]   level;
   logic [9:0]    failsafe_dec;
   logic [SERVO_OUTS-1:0][11:0] servo_pre_vec;
   logic [SERVO_OUTS-1:0][11:0] servo_post_vec;
   rsp_word_type  timeout_word;
   rsp_word_type  frame_word;
   rsp_word_type  lead_word;
   push_ctrl_type push_ctrl;

   function automatic logic [1:0] next_slot(input logic [1:0] slot);
      logic [1:0] result;
      result = (slot == HOP_SLOT_THIRD) ? HOP_SLOT_FIRST : slot + 2'd1;
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Register port: always ready, one write per cycle.
   // ---------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_chan_ff[0]  <= HOP_CHAN_FIRST_RESET;
         hop_chan_ff[1]  <= HOP_CHAN_SECOND_RESET;
         hop_chan_ff[2]  <= HOP_CHAN_THIRD_RESET;
         link_timeout_ff <= LINK_TIMEOUT_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_HOP_CHAN_FIRST:  hop_chan_ff[0]  <= csr_ch.data[7:0];
            CSR_HOP_CHAN_SECOND: hop_chan_ff[1]  <= csr_ch.data[7:0];
            CSR_HOP_CHAN_THIRD:  hop_chan_ff[2]  <= csr_ch.data[7:0];
            CSR_LINK_TIMEOUT:    link_timeout_ff <= csr_ch.data;
         endcase
      end
   end

   function automatic logic [7:0] chan_of(input logic [1:0] slot,
                                          input logic [7:0] first,
                                          input logic [7:0] second,
                                          input logic [7:0] third);
      logic [7:0] result;
      unique case (slot)
         HOP_SLOT_FIRST:  result = first;
         HOP_SLOT_SECOND: result = second;
         HOP_SLOT_THIRD:  result = third;
         default:         result = first;
      endcase
      return result;
   endfunction

   // ---------------------------------------------------------------------
   // Input register. The decoder works on the registered word whenever the
   // result queue has room for the two words it may produce.
   // ---------------------------------------------------------------------
   assign advance      = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.mode        <= req_ch.mode;
         in_word_ff.now_us      <= req_ch.now_us;
         in_word_ff.data_byte   <= req_ch.data_byte;
         in_word_ff.rssi_raw    <= req_ch.rssi_raw;
         in_word_ff.failsafe_in <= req_ch.failsafe_in;
      end
   end

   // ---------------------------------------------------------------------
   // Link timeout check. The elapsed time wraps with the microsecond
   // counter, so a plain 32-bit difference is what is compared.
   // ---------------------------------------------------------------------
   assign elapsed            = in_word_ff.now_us - last_hop_ff;
   assign timeout_hit        = elapsed > {12'd0, link_timeout_ff};
   assign slot_after_timeout = timeout_hit ? next_slot(hop_index_ff) : hop_index_ff;
   assign slot_after_frame   = next_slot(slot_after_timeout);

   // ---------------------------------------------------------------------
   // Byte collection. Byte zero is the tag, then high and low bytes of
   // big-endian words alternate; a word completes on an even count.
   // ---------------------------------------------------------------------
   assign count_plus  = byte_count_ff + 5'd1;
   assign frame_end   = in_word_ff.mode && (count_plus >= 5'(PACKET_BYTES));
   assign servo_word  = {high_byte_ff, in_word_ff.data_byte};
   assign servo_slot  = byte_count_ff[4:1] - 4'd1;
   assign servo_frame = frame_tag_ff == SERVO_TAG;
   assign servo_write = in_word_ff.mode && (byte_count_ff != 5'd0) && !byte_count_ff[0]
                        && servo_frame
                        && (servo_word > SERVO_WORD_LOW) && (servo_word < SERVO_WORD_HIGH);

   always_comb begin
      for (int i = 0; i < SERVO_CHANNELS; i++) begin
         servo_in[i] = servo_ff[i];
         if (servo_write && (servo_slot == 4'(i))) begin
            servo_in[i] = servo_word[12:1];
         end
      end
   end

   // Servo outputs with no matching channel read as zero.
   for (genvar j = 0; j < SERVO_OUTS; j++) begin : g_servo_out
      if (j < SERVO_CHANNELS) begin : g_live
         assign servo_pre_vec[j]  = servo_ff[j];
         assign servo_post_vec[j] = servo_in[j];
      end else begin : g_absent
         assign servo_pre_vec[j]  = 12'd0;
         assign servo_post_vec[j] = 12'd0;
      end
   end

   // ---------------------------------------------------------------------
   // Frame completion: signal strength is clamped and scaled by 25 as a
   // sum of shifts, and the failsafe counter is lowered after servo frames.
   // ---------------------------------------------------------------------
   always_comb begin
      if (in_word_ff.rssi_raw < RSSI_FLOOR) begin
         rssi_clamped = RSSI_FLOOR;
      end else if (in_word_ff.rssi_raw > RSSI_CEILING) begin
         rssi_clamped = RSSI_CEILING;
      end else begin
         rssi_clamped = in_word_ff.rssi_raw;
      end
   end

   assign rssi_offset  = {3'd0, rssi_clamped - RSSI_BASE};
   assign level        = (rssi_offset << 4) + (rssi_offset << 3) + rssi_offset;
   assign failsafe_dec = (in_word_ff.failsafe_in > FAILSAFE_STEP)
                         ? in_word_ff.failsafe_in - FAILSAFE_STEP : 10'd0;

   always_comb begin
      timeout_word.event_kind   = EVENT_TIMEOUT_HOP;
      timeout_word.hop_channel  = chan_of(slot_after_timeout, hop_chan_ff[0],
                                          hop_chan_ff[1], hop_chan_ff[2]);
      timeout_word.servo_value  = servo_pre_vec;
      timeout_word.rssi_level   = 11'd0;
      timeout_word.failsafe_out = in_word_ff.failsafe_in;

      frame_word.event_kind   = servo_frame ? EVENT_FRAME_SERVO : EVENT_FRAME_PLAIN;
      frame_word.hop_channel  = chan_of(slot_after_frame, hop_chan_ff[0],
                                        hop_chan_ff[1], hop_chan_ff[2]);
      frame_word.servo_value  = servo_post_vec;
      frame_word.rssi_level   = level;
      frame_word.failsafe_out = servo_frame ? failsafe_dec : in_word_ff.failsafe_in;

      lead_word             = timeout_hit ? timeout_word : frame_word;
      push_ctrl.lead_valid  = advance && (timeout_hit || frame_end);
      push_ctrl.trail_valid = advance && timeout_hit && frame_end;
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      frame_tag_in  = frame_tag_ff;
      high_byte_in  = high_byte_ff;
      byte_count_in = byte_count_ff;
      if (in_word_ff.mode) begin
         if (byte_count_ff == 5'd0) begin
            frame_tag_in = in_word_ff.data_byte;
         end else if (byte_count_ff[0]) begin
            high_byte_in = in_word_ff.data_byte;
         end
         byte_count_in = frame_end ? 5'd0 : count_plus;
      end
      hop_index_in = frame_end ? slot_after_frame : slot_after_timeout;
      last_hop_in  = (timeout_hit || frame_end) ? in_word_ff.now_us : last_hop_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 5'd0;
         hop_index_ff  <= HOP_SLOT_RESET;
         last_hop_ff   <= 32'd0;
         for (int i = 0; i < SERVO_CHANNELS; i++) begin
            servo_ff[i] <= SERVO_RESET;
         end
      end else if (advance) begin
         byte_count_ff <= byte_count_in;
         hop_index_ff  <= hop_index_in;
         last_hop_ff   <= last_hop_in;
         for (int i = 0; i < SERVO_CHANNELS; i++) begin
            servo_ff[i] <= servo_in[i];
         end
      end
   end

   // Tag and held high byte are always written before they are read.
   always_ff @(posedge clock) begin
      if (advance) begin
         frame_tag_ff <= frame_tag_in;
         high_byte_ff <= high_byte_in;
      end
   end

   rcpdh_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_ctrl  (push_ctrl),
      .lead_word  (lead_word),
      .trail_word (frame_word),
      .room       (room),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: src/rcpdh_checker.sv
// ---------------------------------------------------------------------------
// RC packet decoder port checker
// Watches the result channel of the decoder and flags illegal behaviour.
// ---------------------------------------------------------------------------
module rcpdh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [7:0]  rsp_hop_channel,
   input logic [10:0] rsp_rssi_level
);
   import rcpdh_pkg::*;

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
                                  && $stable(rsp_hop_channel))
      else $error("result word changed while stalled");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // Frame results always carry a mapped signal level within range.
   a_frame_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EVENT_FRAME_PLAIN
                    || rsp_event_kind == EVENT_FRAME_SERVO)
      |-> rsp_rssi_level >= RSSI_LEVEL_MIN && rsp_rssi_level <= RSSI_LEVEL_MAX)
      else $error("frame result with signal level out of range");

   // Timeout hops report no signal level.
   a_timeout_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EVENT_TIMEOUT_HOP |-> rsp_rssi_level == 11'd0)
      else $error("timeout hop with non-zero signal level");

endmodule

bind rc_packet_decode_hop_unit rcpdh_checker u_rcpdh_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_event_kind  (rsp_ch.event_kind),
   .rsp_hop_channel (rsp_ch.hop_channel),
   .rsp_rssi_level  (rsp_ch.rssi_level)
);

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// RC packet decoder testbench
// Self-checking bench for the radio frame decoder with channel hopping. It
// drives input words, register writes and result back-pressure, and checks
// every result word against a cycle-free behavioural model of the decoder.
// ---------------------------------------------------------------------------
module tb;
   import rcpdh_pkg::*;

   // Each point of signal strength above the base adds this much to the level.
   localparam int RSSI_STEP       = 25;
   // Cycles allowed for a word with no result to drain out of the pipeline.
   localparam int IDLE_SETTLE     = 8;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_SQUARE} stall_style_type;

   logic clock;
   logic reset;

   rcpdh_req_if req_ch ();
   rcpdh_rsp_if rsp_ch ();
   rcpdh_csr_if csr_ch ();

   rc_packet_decode_hop_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ------------------------------------------------------------------------
   // Model state of the decoder. It starts at the reset values and is
   // advanced at every clock edge on which a word or a register write is
   // accepted.
   // ------------------------------------------------------------------------
   logic [7:0]   hop_chan [3] = '{HOP_CHAN_FIRST_RESET, HOP_CHAN_SECOND_RESET,
                                  HOP_CHAN_THIRD_RESET};
   logic [19:0]  link_timeout = LINK_TIMEOUT_RESET;
   logic [7:0]   frame_tag = '0;
   logic [7:0]   high_byte = '0;
   logic [4:0]   byte_index = '0;
   logic [11:0]  servo_now [SERVO_OUTS] = '{default: SERVO_RESET};
   logic [1:0]   hop_slot = HOP_SLOT_RESET;
   logic [31:0]  last_hop_us = '0;

   // Result words that the model has produced and the block has yet to give.
   rsp_word_type hop_frame_results [$];

   int           mismatch_total = 0;
   int           results_seen = 0;

   // Stimulus side bookkeeping: position within the current frame, the time
   // cursor, the timeout last written, the remaining length of the burst and
   // the number of input words sent so far.
   int           frame_pos = 0;
   logic [31:0]  time_cursor = '0;
   logic [19:0]  stim_timeout = LINK_TIMEOUT_RESET;
   int           burst_left = 0;
   int           words_sent = 0;

   // ------------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Any handshake on any channel counts as progress. A run that goes quiet
   // for too long, including one that waits for a result that never comes,
   // is failed here.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------

   // Moves to the next hop slot, round-robin over the three channels, and
   // gives the channel number of the new slot.
   function automatic logic [7:0] advance_hop();
      if (hop_slot == HOP_SLOT_THIRD) begin
         hop_slot = HOP_SLOT_FIRST;
      end else begin
         hop_slot = hop_slot + 2'd1;
      end
      return hop_chan[hop_slot];
   endfunction

   // Builds a result word; the servo fields always carry the current values.
   function automatic rsp_word_type make_result(input logic [1:0] kind,
                                                input logic [7:0] chan,
                                                input logic [10:0] level,
                                                input logic [9:0] failsafe);
      rsp_word_type r;
      int           i;
      r.event_kind  = kind;
      r.hop_channel = chan;
      for (i = 0; i < SERVO_OUTS; i++) begin
         r.servo_value[i] = servo_now[i];
      end
      r.rssi_level   = level;
      r.failsafe_out = failsafe;
      return r;
   endfunction

   // Works out the result words of one accepted input word. The link-loss
   // check comes first, so when a frame ends on a word that also times out
   // the timeout hop result is queued ahead of the frame result.
   task automatic decode_hop_step(input req_word_type w);
      logic [31:0] elapsed;
      logic [15:0] word;
      logic [7:0]  rssi_clamped;
      logic [10:0] level;
      int          slot;
      elapsed = w.now_us - last_hop_us;
      if (elapsed > 32'(link_timeout)) begin
         last_hop_us = w.now_us;
         hop_frame_results.push_back(make_result(EVENT_TIMEOUT_HOP, advance_hop(), 11'd0,
                                                 w.failsafe_in));
      end
      if (w.mode) begin
         if (byte_index == 5'd0) begin
            frame_tag = w.data_byte;
         end else if (byte_index[0]) begin
            high_byte = w.data_byte;
         end else begin
            // Every even position completes a big-endian word for one servo.
            slot = (int'(byte_index) - 2) / 2;
            word = {high_byte, w.data_byte};
            if (frame_tag == SERVO_TAG && slot < SERVO_CHANNELS_DEF
                && word > SERVO_WORD_LOW && word < SERVO_WORD_HIGH) begin
               servo_now[slot] = word[12:1];
            end
         end
         byte_index = byte_index + 5'd1;
         if (byte_index >= PACKET_BYTES) begin
            byte_index   = '0;
            rssi_clamped = w.rssi_raw;
            if (rssi_clamped < RSSI_FLOOR) begin
               rssi_clamped = RSSI_FLOOR;
            end
            if (rssi_clamped > RSSI_CEILING) begin
               rssi_clamped = RSSI_CEILING;
            end
            level       = 11'((int'(rssi_clamped) - int'(RSSI_BASE)) * RSSI_STEP);
            last_hop_us = w.now_us;
            if (frame_tag == SERVO_TAG) begin
               hop_frame_results.push_back(make_result(EVENT_FRAME_SERVO, advance_hop(), level,
                  (w.failsafe_in > FAILSAFE_STEP) ? w.failsafe_in - FAILSAFE_STEP : 10'd0));
            end else begin
               hop_frame_results.push_back(make_result(EVENT_FRAME_PLAIN, advance_hop(), level,
                                                       w.failsafe_in));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_total++;
      $display("mismatch at result word %0d: %s is %0d, should be %0d",
               results_seen, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic check_result();
      rsp_word_type want;
      if (hop_frame_results.size() == 0) begin
         report_mismatch("result word with none outstanding, event_kind",
                         rsp_ch.event_kind, 0);
      end else begin
         want = hop_frame_results.pop_front();
         compare_field("event_kind", rsp_ch.event_kind, want.event_kind);
         compare_field("hop_channel", rsp_ch.hop_channel, want.hop_channel);
         compare_field("roll_value", rsp_ch.roll_value, want.servo_value[0]);
         compare_field("pitch_value", rsp_ch.pitch_value, want.servo_value[1]);
         compare_field("throttle_value", rsp_ch.throttle_value, want.servo_value[2]);
         compare_field("yaw_value", rsp_ch.yaw_value, want.servo_value[3]);
         compare_field("aux_one_value", rsp_ch.aux_one_value, want.servo_value[4]);
         compare_field("aux_two_value", rsp_ch.aux_two_value, want.servo_value[5]);
         compare_field("aux_three_value", rsp_ch.aux_three_value, want.servo_value[6]);
         compare_field("aux_four_value", rsp_ch.aux_four_value, want.servo_value[7]);
         compare_field("rssi_level", rsp_ch.rssi_level, want.rssi_level);
         compare_field("failsafe_out", rsp_ch.failsafe_out, want.failsafe_out);
      end
      results_seen++;
   endtask

   // Everything is sampled just after the rising edge, when the values seen
   // are still those on which the block acted at that edge. Input words are
   // modelled before result words are checked, so a word's results are always
   // queued before they can be compared.
   always @(posedge clock) begin : decoder_monitor
      req_word_type taken;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            taken.mode        = req_ch.mode;
            taken.now_us      = req_ch.now_us;
            taken.data_byte   = req_ch.data_byte;
            taken.rssi_raw    = req_ch.rssi_raw;
            taken.failsafe_in = req_ch.failsafe_in;
            decode_hop_step(taken);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_HOP_CHAN_FIRST:  hop_chan[HOP_SLOT_FIRST]  = csr_ch.data[7:0];
               CSR_HOP_CHAN_SECOND: hop_chan[HOP_SLOT_SECOND] = csr_ch.data[7:0];
               CSR_HOP_CHAN_THIRD:  hop_chan[HOP_SLOT_THIRD]  = csr_ch.data[7:0];
               CSR_LINK_TIMEOUT:    link_timeout              = csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result back-pressure. The consumer switches at random between styles of
   // stalling, including spells where it never stalls at all.
   // ------------------------------------------------------------------------
   initial begin : result_sink
      stall_style_type style;
      int              style_left;
      int              phase;
      rsp_ch.ready <= 1'b0;
      style      = STALL_NONE;
      style_left = 0;
      phase      = 0;
      forever begin
         @(posedge clock);
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 120);
         end
         style_left--;
         phase++;
         case (style)
            STALL_NONE:   rsp_ch.ready <= 1'b1;
            STALL_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ch.ready <= (phase % 8 < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Sends one input word and returns at the edge on which it is accepted.
   // Words go out in bursts; before the shorter bursts the channel idles with
   // rubbish on the payload, which the block must ignore.
   task automatic send_word(input logic mode, input logic [31:0] now, input logic [7:0] data,
                            input logic [7:0] rssi, input logic [9:0] failsafe);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 80);
         end else begin
            burst_left = $urandom_range(1, 12);
            req_ch.valid       <= 1'b0;
            req_ch.mode        <= 1'($urandom_range(0, 1));
            req_ch.now_us      <= $urandom();
            req_ch.data_byte   <= 8'($urandom());
            req_ch.rssi_raw    <= 8'($urandom());
            req_ch.failsafe_in <= 10'($urandom());
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.now_us      <= now;
      req_ch.data_byte   <= data;
      req_ch.rssi_raw    <= rssi;
      req_ch.failsafe_in <= failsafe;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      words_sent++;
      if (mode) begin
         frame_pos = (frame_pos + 1) % PACKET_BYTES;
      end
   endtask

   // Waits until every outstanding result has arrived and the last word has
   // drained, so that registers may be written safely. The first edge lets
   // the monitor catch up with a word accepted at the current edge.
   task automatic settle_decoder();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (hop_frame_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Writes one register. The valid is left high so that back-to-back writes
   // never lower and raise it within one time step.
   task automatic write_csr(input logic [1:0] index, input logic [19:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic configure_hops(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] third, input logic [19:0] timeout);
      write_csr(CSR_HOP_CHAN_FIRST, {12'd0, first});
      write_csr(CSR_HOP_CHAN_SECOND, {12'd0, second});
      write_csr(CSR_HOP_CHAN_THIRD, {12'd0, third});
      write_csr(CSR_LINK_TIMEOUT, timeout);
      csr_ch.valid <= 1'b0;
      stim_timeout = timeout;
   endtask

   // Time mostly creeps forward in small steps; now and then it jumps past
   // the timeout, lands just on it, or goes anywhere in the 32-bit range.
   function automatic logic [31:0] next_now();
      case ($urandom_range(0, 19))
         0:       time_cursor = $urandom();
         1, 2:    time_cursor = time_cursor + stim_timeout + 32'd1 + $urandom_range(0, 4000);
         3:       time_cursor = time_cursor + stim_timeout;
         default: time_cursor = time_cursor + $urandom_range(0, 300);
      endcase
      return time_cursor;
   endfunction

   function automatic logic [7:0] pick_rssi();
      logic [7:0] edges [6];
      edges = '{8'd0, RSSI_FLOOR - 8'd1, RSSI_FLOOR, RSSI_CEILING, RSSI_CEILING + 8'd1, 8'd255};
      if ($urandom_range(0, 4) == 0) begin
         return edges[$urandom_range(0, 5)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [9:0] pick_failsafe();
      logic [9:0] edges [5];
      edges = '{10'd0, FAILSAFE_STEP - 10'd1, FAILSAFE_STEP, FAILSAFE_STEP + 10'd1, 10'd1023};
      if ($urandom_range(0, 4) == 0) begin
         return edges[$urandom_range(0, 4)];
      end
      return 10'($urandom_range(0, 1023));
   endfunction

   // Servo words: mostly inside the accepted window, some on its edges and
   // some anywhere in the 16-bit range.
   function automatic logic [15:0] pick_servo_word();
      logic [15:0] edges [4];
      edges = '{SERVO_WORD_LOW, SERVO_WORD_LOW + 16'd1, SERVO_WORD_HIGH - 16'd1, SERVO_WORD_HIGH};
      case ($urandom_range(0, 5))
         0:       return edges[$urandom_range(0, 3)];
         1:       return 16'($urandom());
         default: return 16'($urandom_range(SERVO_WORD_LOW + 1, SERVO_WORD_HIGH - 1));
      endcase
   endfunction

   // Sends the first byte_total bytes of a frame, tagged as a servo frame or
   // with a random tag. A frame left unfinished earlier is first padded out
   // with random bytes so that the new one starts on a frame boundary.
   // Time-check-only words are sprinkled between the bytes.
   task automatic send_frame(input bit servo, input int byte_total);
      logic [15:0] word;
      logic [7:0]  data;
      int          b;
      word = '0;
      while (frame_pos != 0) begin
         send_word(1'b1, next_now(), 8'($urandom()), pick_rssi(), pick_failsafe());
      end
      for (b = 0; b < byte_total; b++) begin
         if (b == 0) begin
            data = servo ? SERVO_TAG : 8'($urandom_range(0, 255));
         end else if (b % 2 == 1) begin
            word = pick_servo_word();
            data = word[15:8];
         end else begin
            data = word[7:0];
         end
         if ($urandom_range(0, 5) == 0) begin
            send_word(1'b0, next_now(), 8'($urandom()), pick_rssi(), pick_failsafe());
         end
         send_word(1'b1, next_now(), data, pick_rssi(), pick_failsafe());
      end
   endtask

   // Random traffic: mainly whole frames, with some noise, truncated frames
   // and runs of bare time checks. Every word sent counts towards the budget.
   task automatic random_traffic(input int word_budget);
      int start;
      int n;
      start = words_sent;
      while (words_sent - start < word_budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_frame(1'b1, PACKET_BYTES);
            end
            5, 6: begin
               send_frame(1'b0, PACKET_BYTES);
            end
            7: begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  send_word(1'($urandom_range(0, 1)), next_now(), 8'($urandom()), pick_rssi(),
                            pick_failsafe());
               end
            end
            8: begin
               n = $urandom_range(1, PACKET_BYTES - 1);
               send_frame(1'b1, n);
            end
            default: begin
               n = $urandom_range(1, 5);
               repeat (n) begin
                  send_word(1'b0, next_now(), 8'($urandom()), pick_rssi(), pick_failsafe());
               end
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Timeout edges with the reset configuration: an elapsed time equal to the
   // timeout does not hop, one more microsecond does, and the elapsed time is
   // reckoned across the wrap of the 32-bit time counter.
   task automatic test_timeout_boundaries();
      send_word(1'b0, 32'(LINK_TIMEOUT_RESET), 8'hFF, 8'd0, 10'd0);
      send_word(1'b0, 32'(LINK_TIMEOUT_RESET) + 32'd1, 8'h00, 8'd255, 10'd1023);
      send_word(1'b0, 32'hFFFF_FFF0, 8'hA5, RSSI_FLOOR - 8'd1, FAILSAFE_STEP + 10'd1);
      send_word(1'b0, 32'h0000_0100, 8'h5A, RSSI_CEILING + 8'd1, FAILSAFE_STEP - 10'd1);
   endtask

   // One servo frame holding words on both edges of the accepted window and at
   // the extremes of the 16-bit range. Time jumps past the timeout in the
   // middle of the frame, so a hop lands while bytes are still being
   // gathered, and again on the last byte, so that word gives a timeout hop
   // followed by the frame result.
   task automatic test_servo_frame();
      logic [15:0] words [8];
      logic [31:0] t;
      logic [7:0]  data;
      int          b;
      words = '{SERVO_WORD_LOW, SERVO_WORD_LOW + 16'd1, SERVO_WORD_HIGH - 16'd1,
                SERVO_WORD_HIGH, 16'h0000, 16'hFFFF, 16'd3000, 16'h0A5A};
      t = 32'h0000_0100;
      for (b = 0; b < PACKET_BYTES; b++) begin
         t = t + 32'd10;
         if (b == 6 || b == PACKET_BYTES - 1) begin
            t = t + 32'(LINK_TIMEOUT_RESET) + 32'd1;
         end
         if (b == 0) begin
            data = SERVO_TAG;
         end else if (b % 2 == 1) begin
            data = words[(b - 1) / 2][15:8];
         end else begin
            data = words[(b - 2) / 2][7:0];
         end
         if (b == PACKET_BYTES - 1) begin
            send_word(1'b1, t, data, 8'd255, 10'd15);
         end else begin
            send_word(1'b1, t, data, pick_rssi(), pick_failsafe());
         end
      end
      time_cursor = t;
   endtask

   task automatic test_default_config_traffic();
      random_traffic(100);
   endtask

   // Channel numbers at their extremes and a long timeout of 1000000.
   task automatic test_extreme_config_traffic();
      settle_decoder();
      configure_hops(8'd0, 8'd255, 8'd128, 20'd1000000);
      random_traffic(100);
   endtask

   // A zero timeout hops on every word whose time differs from the last hop.
   task automatic test_zero_timeout_traffic();
      settle_decoder();
      configure_hops(8'd255, 8'd0, 8'($urandom()), 20'd0);
      random_traffic(60);
   endtask

   task automatic test_random_config_traffic();
      settle_decoder();
      configure_hops(8'($urandom()), 8'($urandom()), 8'($urandom()),
                     20'($urandom_range(2, 60000)));
      random_traffic(120);
   endtask

   // A short timeout makes frames often time out part of the way through.
   task automatic test_short_timeout_traffic();
      settle_decoder();
      configure_hops(8'($urandom()), 8'($urandom()), 8'($urandom()),
                     20'($urandom_range(200, 2000)));
      random_traffic(100);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= 1'b0;
      req_ch.now_us      <= '0;
      req_ch.data_byte   <= '0;
      req_ch.rssi_raw    <= '0;
      req_ch.failsafe_in <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_HOP_CHAN_FIRST;
      csr_ch.data        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_timeout_boundaries();
      test_servo_frame();
      test_default_config_traffic();
      test_extreme_config_traffic();
      test_zero_timeout_traffic();
      test_random_config_traffic();
      test_short_timeout_traffic();

      // Let the last results drain, then allow a little longer so that any
      // stray result word would still be caught.
      settle_decoder();
      repeat (4 * IDLE_SETTLE) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
